// ===== rtl/imufp_pkg.sv =====
// Shared constants and types for the attitude sensor frame parser.
package imufp_pkg;

    // Frame layout
    localparam int FRAME_LEN = 18;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int FILL_W    = $clog2(FRAME_LEN + 1);
    localparam int TOTAL_W   = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;

    // Turn bookkeeping
    localparam logic signed [TOTAL_W-1:0] TURN_HUNDREDTHS = 32'sd36000;
    localparam logic signed [WORD_W-1:0]  TURN_LIMIT      = 16'sd32767;

    // Configuration registers
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_WRAP_THRESHOLD = 2'd0;
    localparam logic [WORD_W-1:0]     WRAP_THRESHOLD_RST = 16'd30000;

    // Updated tracking values handed from the turn tracker to the output stage
    typedef struct packed {
        logic signed [WORD_W-1:0]  turns;
        logic signed [TOTAL_W-1:0] total_yaw;
        logic [WORD_W-1:0]         frame_number;
    } t_track;

endpackage

// ===== rtl/imu_frame_parser_yaw_unwrap.sv =====
// Top level of the attitude sensor frame parser with yaw turn counting.
// One byte is taken per cycle on the slave stream, unless intake stalls, into a chain
// of 18 byte cells; each time the chain holds 18 bytes since the last frame, the
// cycle after the last byte checks the 0x5A 0x5A header and the running 8-bit
// checksum, and a valid frame loads the output register. Intake stalls only while a
// frame is found and the output register still holds an untaken result.
// wrap_threshold sits at APB address 0.
module imu_frame_parser_yaw_unwrap (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // rx_byte[7:0]
    input  logic [7:0]   s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // gyro_x[15:0] gyro_y[31:16] gyro_z[47:32] yaw[63:48] pitch[79:64]
    // roll[95:80] device_status[103:96] turns[119:104] total_yaw[151:120]
    // frame_number[167:152]
    output logic [167:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [imufp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [imufp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [imufp_pkg::APB_DATA_W-1:0] prdata,
    output logic         pready
);
    import imufp_pkg::*;

    logic [BYTE_W-1:0] w [FRAME_LEN];
    logic [BYTE_W-1:0] r_sum;
    logic [FILL_W-1:0] r_fill;
    logic              r_chk;
    logic [WORD_W-1:0] r_threshold;
    logic              r_out_valid;
    logic [167:0]      r_out_data;

    logic [BYTE_W-1:0] n_sum;
    logic [FILL_W-1:0] n_fill;
    logic              n_chk;
    logic              accept;
    logic              can_load;
    logic              frame_ok;
    logic              fire;
    logic [WORD_W-1:0] yaw;
    t_track            track;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_WRAP_THRESHOLD) ? {16'd0, r_threshold} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= WRAP_THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready &&
                     paddr == REG_WRAP_THRESHOLD) begin
            r_threshold <= pwdata[WORD_W-1:0];
        end
    end

    // Chain of byte cells, newest byte enters at the top
    genvar k;
    generate
        for (k = 0; k < FRAME_LEN; k++) begin : g_cell
            logic [BYTE_W-1:0] cell_in;
            if (k == FRAME_LEN - 1) begin : g_top
                assign cell_in = s_tdata;
            end else begin : g_mid
                assign cell_in = w[k+1];
            end
            imufp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (accept),
                .i_byte  (cell_in),
                .o_byte  (w[k])
            );
        end
    endgenerate

    // Check the window that the last byte completed
    assign can_load = !r_out_valid || m_tready;
    assign frame_ok = (w[0] == SYNC_BYTE) && (w[1] == SYNC_BYTE) &&
                      (r_sum == w[FRAME_LEN-1]);
    assign fire     = r_chk && frame_ok && can_load;
    assign s_tready = !r_chk || !frame_ok || can_load;
    assign accept   = s_tvalid && s_tready;
    assign yaw      = {w[10], w[11]};

    // Running sum of bytes 0..16: drop the oldest, add the one moving down
    always_comb begin
        n_sum = accept ? (r_sum - w[0] + w[FRAME_LEN-1]) : r_sum;
    end

    // Fill count and pending check
    always_comb begin
        n_fill = r_fill;
        if (fire) begin
            n_fill = accept ? FILL_W'(1) : '0;
        end else if (accept && r_fill < FILL_W'(FRAME_LEN)) begin
            n_fill = r_fill + FILL_W'(1);
        end
        if (accept) begin
            n_chk = !fire && (r_fill >= FILL_W'(FRAME_LEN - 1));
        end else begin
            n_chk = r_chk && frame_ok && !can_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_chk  <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_fill <= n_fill;
            r_chk  <= n_chk;
        end
    end

    imufp_turn_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_yaw       (yaw),
        .i_threshold (r_threshold),
        .o_next      (track)
    );

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {track.frame_number, track.total_yaw, track.turns, w[16],
                           w[14], w[15], w[12], w[13], w[10], w[11],
                           w[8], w[9], w[6], w[7], w[4], w[5]};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ===== rtl/imufp_cell.sv =====
// One byte cell of the sliding frame window.
module imufp_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [imufp_pkg::BYTE_W-1:0] i_byte,
    output logic [imufp_pkg::BYTE_W-1:0] o_byte
);
    import imufp_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    // Take the incoming byte (the neighbor's, or the stream byte at the top) on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== rtl/imufp_turn_tracker.sv =====
// Yaw turn counter, total yaw offset and frame counter.
module imufp_turn_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [imufp_pkg::WORD_W-1:0] i_yaw,
    input  logic [imufp_pkg::WORD_W-1:0] i_threshold,
    output imufp_pkg::t_track            o_next
);
    import imufp_pkg::*;

    logic [WORD_W-1:0]         r_prev_yaw;
    logic signed [WORD_W-1:0]  r_turns;
    logic signed [TOTAL_W-1:0] r_offset;
    logic [WORD_W-1:0]         r_frames;

    logic signed [WORD_W-1:0]  n_turns;
    logic signed [TOTAL_W-1:0] n_offset;
    logic signed [WORD_W+1:0]  rise;
    logic signed [WORD_W+1:0]  drop;
    logic signed [WORD_W+1:0]  thr_ext;
    logic                      turn_up;
    logic                      turn_down;

    // Detect a wrap in either direction
    always_comb begin
        rise      = $signed({2'b00, i_yaw}) - $signed({2'b00, r_prev_yaw});
        drop      = $signed({2'b00, r_prev_yaw}) - $signed({2'b00, i_yaw});
        thr_ext   = $signed({2'b00, i_threshold});
        turn_up   = (drop > thr_ext) && (r_turns != TURN_LIMIT);
        turn_down = (rise > thr_ext) && (r_turns != -TURN_LIMIT);
    end

    // Step the turn count and its offset in hundredths together
    always_comb begin
        n_turns  = r_turns;
        n_offset = r_offset;
        if (turn_up) begin
            n_turns  = r_turns + 16'sd1;
            n_offset = r_offset + TURN_HUNDREDTHS;
        end else if (turn_down) begin
            n_turns  = r_turns - 16'sd1;
            n_offset = r_offset - TURN_HUNDREDTHS;
        end
        o_next.turns        = n_turns;
        o_next.total_yaw    = n_offset + $signed({16'd0, i_yaw});
        o_next.frame_number = r_frames + 16'd1;
    end

    // Commit on each valid frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_yaw <= '0;
            r_turns    <= '0;
            r_offset   <= '0;
            r_frames   <= '0;
        end else if (i_fire) begin
            r_prev_yaw <= i_yaw;
            r_turns    <= n_turns;
            r_offset   <= n_offset;
            r_frames   <= o_next.frame_number;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the attitude sensor frame parser with yaw turn counting.
`timescale 1ns / 100ps

module tb_top;
    import imufp_pkg::*;

    localparam int N_PHASES      = 7;
    localparam int PHASE_BYTES   = 85;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 6;

    // Result fields, highest first so the struct lines up with m_tdata
    typedef struct packed {
        logic [15:0]        frame_number;
        logic signed [31:0] total_yaw;
        logic signed [15:0] turns;
        logic [7:0]         device_status;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [15:0]        yaw;
        logic signed [15:0] gyro_z;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
    } t_imu_result;

    typedef struct {
        logic [7:0]  data;
        bit          has_fixed;
        t_imu_result fixed;
    } t_stim_row;

    typedef enum int {SEG_GOOD, SEG_BAD_SUM, SEG_BAD_HDR, SEG_CUT, SEG_NOISE} t_seg_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic [7:0]            s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [167:0]          m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Parser state as predicted
    logic [7:0]         frame_win [FRAME_LEN];
    int                 frame_fill;
    logic [15:0]        last_yaw;
    logic signed [15:0] turn_cnt;
    logic [15:0]        frame_cnt;
    logic [15:0]        wrap_thr;

    t_imu_result frames_due [$];
    t_stim_row   dir_rows [$];

    logic [15:0] gen_yaw;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_req;
    int          bytes_sent;
    int          frames_predicted;
    int          frames_checked;
    int          fault_cnt;
    int          turns_min;
    int          turns_max;

    imu_frame_parser_yaw_unwrap dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the predicted parser by one byte; return 1 when a frame completes
    function automatic bit advance_parser(input logic [7:0] b, output t_imu_result r);
        logic [7:0]  sum;
        logic [15:0] yaw;
        int          diff;
        int          thr;
        r = '0;
        if (frame_fill < FRAME_LEN) begin
            frame_win[frame_fill] = b;
            frame_fill++;
        end else begin
            for (int i = 0; i < FRAME_LEN - 1; i++) frame_win[i] = frame_win[i + 1];
            frame_win[FRAME_LEN - 1] = b;
        end
        if (frame_fill < FRAME_LEN) return 1'b0;
        if (frame_win[0] != SYNC_BYTE || frame_win[1] != SYNC_BYTE) return 1'b0;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame_win[i];
        if (sum != frame_win[FRAME_LEN - 1]) return 1'b0;

        // Count a turn on a large yaw jump, saturating both ways
        yaw  = {frame_win[10], frame_win[11]};
        thr  = int'(wrap_thr);
        diff = int'(yaw) - int'(last_yaw);
        if (diff < -thr) begin
            if (turn_cnt < TURN_LIMIT) turn_cnt++;
        end else if (-diff < -thr) begin
            if (turn_cnt > -TURN_LIMIT) turn_cnt--;
        end
        last_yaw  = yaw;
        frame_cnt = frame_cnt + 16'd1;

        r.gyro_x        = {frame_win[4], frame_win[5]};
        r.gyro_y        = {frame_win[6], frame_win[7]};
        r.gyro_z        = {frame_win[8], frame_win[9]};
        r.yaw           = yaw;
        r.pitch         = {frame_win[12], frame_win[13]};
        r.roll          = {frame_win[14], frame_win[15]};
        r.device_status = frame_win[16];
        r.turns         = turn_cnt;
        r.total_yaw     = int'(yaw) + int'(TURN_HUNDREDTHS) * int'(turn_cnt);
        r.frame_number  = frame_cnt;
        frame_fill = 0;
        return 1'b1;
    endfunction

    function automatic bit field_ok(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Check each output transaction against the oldest expected frame
    always @(posedge i_clk) begin
        t_imu_result got;
        t_imu_result want;
        bit          ok;
        if (i_rst_n === 1'b1 && m_tvalid && m_tready) begin
            got = t_imu_result'(m_tdata);
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected result, actual frame_number %0d", $time,
                         got.frame_number);
                fault_cnt++;
            end else begin
                want = frames_due.pop_front();
                ok = 1'b1;
                ok &= field_ok("gyro_x", want.gyro_x, got.gyro_x);
                ok &= field_ok("gyro_y", want.gyro_y, got.gyro_y);
                ok &= field_ok("gyro_z", want.gyro_z, got.gyro_z);
                ok &= field_ok("yaw", want.yaw, got.yaw);
                ok &= field_ok("pitch", want.pitch, got.pitch);
                ok &= field_ok("roll", want.roll, got.roll);
                ok &= field_ok("device_status", want.device_status, got.device_status);
                ok &= field_ok("turns", want.turns, got.turns);
                ok &= field_ok("total_yaw", want.total_yaw, got.total_yaw);
                ok &= field_ok("frame_number", want.frame_number, got.frame_number);
                if (!ok) fault_cnt++;
                frames_checked++;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin : rx_side
        int stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, wait for its transaction, then predict
    task automatic push_byte(input logic [7:0] b, input bit use_fixed,
                             input t_imu_result fixed);
        int          gap;
        t_imu_result r;
        bit          found;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
        found = advance_parser(b, r);
        if (use_fixed) begin
            frames_due.push_back(fixed);
            frames_predicted++;
        end else if (found) begin
            frames_due.push_back(r);
            frames_predicted++;
        end
        if (found) begin
            if (int'(turn_cnt) < turns_min) turns_min = int'(turn_cnt);
            if (int'(turn_cnt) > turns_max) turns_max = int'(turn_cnt);
        end
    endtask

    task automatic release_tx();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    // Hold the sender until every expected frame is out, then let the block settle
    task automatic drain();
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == REG_WRAP_THRESHOLD) wrap_thr = data[15:0];
        @(negedge i_clk);
        // Read back the register just written
        if (addr == REG_WRAP_THRESHOLD && prdata !== {16'd0, data[15:0]}) begin
            $display("%0t: mismatch on prdata: expected %0d, actual %0d", $time,
                     {16'd0, data[15:0]}, prdata);
            fault_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Aim yaw at the turn threshold edges around the last good frame, near it, at 0 or 65535, a turn away, or at random
    function automatic logic [15:0] pick_yaw();
        int y;
        int thr;
        thr = int'(wrap_thr);
        case ($urandom_range(0, 7))
            0, 1: y = $urandom_range(0, 65535);
            2:    y = int'(gen_yaw) - thr - $urandom_range(0, 1);
            3:    y = int'(gen_yaw) + thr + $urandom_range(0, 1);
            4:    y = int'(gen_yaw) + $urandom_range(0, 200) - 100;
            5:    y = ($urandom_range(0, 1) == 0) ? 0 : 65535;
            default: y = int'(gen_yaw) + (($urandom_range(0, 1) == 0) ? 36000 : -36000);
        endcase
        if (y < 0 || y > 65535) y = $urandom_range(0, 65535);
        return y[15:0];
    endfunction

    // Send one frame, a damaged frame, a cut frame or a few noise bytes
    task automatic send_segment(input bit force_good);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] yaw;
        logic [7:0]  sum;
        t_seg_kind   kind;
        int          pick;
        int          n;
        pick = $urandom_range(0, 99);
        if (force_good || pick < 70)  kind = SEG_GOOD;
        else if (pick < 78)           kind = SEG_BAD_SUM;
        else if (pick < 85)           kind = SEG_BAD_HDR;
        else if (pick < 92)           kind = SEG_CUT;
        else                          kind = SEG_NOISE;

        if (kind == SEG_NOISE) begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(($urandom_range(0, 2) == 0) ? SYNC_BYTE
                                 : 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            yaw   = pick_yaw();
            fb[0] = SYNC_BYTE;
            fb[1] = SYNC_BYTE;
            for (int i = 2; i < FRAME_LEN - 1; i++) fb[i] = 8'($urandom_range(0, 255));
            fb[10] = yaw[15:8];
            fb[11] = yaw[7:0];
            sum = '0;
            for (int i = 0; i < FRAME_LEN - 1; i++) sum += fb[i];
            fb[FRAME_LEN - 1] = sum;
            if (kind == SEG_BAD_SUM) fb[FRAME_LEN - 1] = sum ^ 8'($urandom_range(1, 255));
            if (kind == SEG_BAD_HDR) begin
                pick = $urandom_range(0, 1);
                fb[pick] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
            end
            n = (kind == SEG_CUT) ? $urandom_range(3, FRAME_LEN - 1) : FRAME_LEN;
            for (int i = 0; i < n; i++) push_byte(fb[i], 1'b0, '0);
            if (kind == SEG_GOOD) gen_yaw = yaw;
        end
    endtask

    initial begin : stimulus
        int          phase_bytes;
        logic [15:0] thr;
        i_rst_n  = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_req = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (frame_win[i]) frame_win[i] = '0;
        frame_fill = 0;
        last_yaw   = '0;
        turn_cnt   = '0;
        frame_cnt  = '0;
        wrap_thr   = WRAP_THRESHOLD_RST;
        gen_yaw    = '0;
        bytes_sent = 0;
        frames_predicted = 0;
        frames_checked   = 0;
        fault_cnt  = 0;
        turns_min  = 0;
        turns_max  = 0;

        // Directed bytes: a stray lead byte, then one frame of extreme values.
        // The stray byte fills the window with a bad header first, so the frame
        // is only found after the window slides by one.
        dir_rows.push_back('{8'h00, 1'b0, '0});
        begin : fill_table
            logic [7:0] body [17];
            t_imu_result hit;
            body = '{8'h5A, 8'h5A, 8'h00, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF};
            foreach (body[i]) dir_rows.push_back('{body[i], 1'b0, '0});
            // Yaw jumps from 0 to 65535: one turn down under the reset threshold
            hit = '{frame_number: 16'd1, total_yaw: 32'sd29535, turns: -16'sd1,
                    device_status: 8'hFF, roll: 16'sh7FFF, pitch: 16'sh0000,
                    yaw: 16'hFFFF, gyro_z: 16'shFFFF, gyro_y: 16'sh7FFF,
                    gyro_x: 16'sh8000};
            dir_rows.push_back('{8'h2B, 1'b1, hit});
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) push_byte(dir_rows[i].data, dir_rows[i].has_fixed,
                                        dir_rows[i].fixed);
        release_tx();
        gen_yaw = 16'hFFFF;

        // Random phases, each under its own threshold
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain();
            case (phase)
                0:       thr = 16'd0;
                1:       thr = 16'd36000;
                2:       thr = 16'hFFFF;
                4:       thr = 16'd1;
                5:       thr = WRAP_THRESHOLD_RST;
                default: thr = 16'($urandom_range(2, 35999));
            endcase
            apb_write(REG_WRAP_THRESHOLD, {16'($urandom_range(0, 65535)), thr});
            tx_idle_on = (phase != N_PHASES - 1);
            rx_idle_on = (phase != N_PHASES - 1) && (phase != 3);
            phase_bytes = bytes_sent;

            // Long receiver hold-off with frames sent back to back
            if (phase == 2) begin
                tx_idle_on = 1'b0;
                hold_req   = 1'b1;
                repeat (4) send_segment(1'b1);
                tx_idle_on = 1'b1;
            end
            while (bytes_sent - phase_bytes < PHASE_BYTES)
                send_segment(1'b0);
            release_tx();
        end

        drain();
        $display("run covered %0d bytes, %0d predicted and %0d checked frames",
                 bytes_sent, frames_predicted, frames_checked);
        $display("over %0d threshold settings; turn count ranged from %0d to %0d",
                 N_PHASES + 1, turns_min, turns_max);
        if (fault_cnt == 0 && frames_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("timeout with %0d frames outstanding", frames_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
